// File: rtl/smix_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smix_pkg
// Shared beat formats, command kinds and voice table entry for the mixer.
// ----------------------------------------------------------------------------
package smix_pkg;

  // Command kinds carried in the kind field of an input beat
  localparam logic [2:0] KIND_TICK   = 3'd0;
  localparam logic [2:0] KIND_LOAD   = 3'd1;
  localparam logic [2:0] KIND_START  = 3'd2;
  localparam logic [2:0] KIND_STOP   = 3'd3;
  localparam logic [2:0] KIND_VOLUME = 3'd4;

  localparam logic [9:0]         VOL_MAX         = 10'd256;
  localparam logic signed [15:0] OUT_MAX         = 16'sh7FFF;
  localparam logic signed [15:0] OUT_MIN         = -16'sh8000;
  localparam logic        [15:0] STEP_RATE_RESET = 16'((22050 << 8) / 44100);

  typedef struct packed {
    logic        [2:0]  kind;
    logic        [3:0]  channel;
    logic        [15:0] sample_address;
    logic signed [15:0] sample_word;
    logic        [16:0] sample_length;
    logic        [9:0]  volume;
    logic signed [15:0] loop_count;
    logic signed [15:0] music_left;
    logic signed [15:0] music_right;
  } item_t;

  typedef struct packed {
    logic signed [15:0] out_left;
    logic signed [15:0] out_right;
  } result_t;

  // One voice table entry; position is 17.8 fixed point in sample words
  typedef struct packed {
    logic        [15:0] base;
    logic        [16:0] length;
    logic        [24:0] position;
    logic        [8:0]  volume;
    logic signed [15:0] loops;
  } voice_entry_t;

endpackage

// File: rtl/smix_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smix_cfg
// Register port: effect enable and playback step rate.
// ----------------------------------------------------------------------------
module smix_cfg (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic        sfx_enable,
  output logic [15:0] step_rate
);
  import smix_pkg::*;

  localparam logic REG_SFX_ENABLE = 1'b0;
  localparam logic REG_STEP_RATE  = 1'b1;

  logic reg_index;
  logic wr_strobe;

  assign pready    = 1'b1;
  assign reg_index = paddr[2];
  assign wr_strobe = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sfx_enable <= 1'b1;
      step_rate  <= STEP_RATE_RESET;
    end else if (wr_strobe) begin
      case (reg_index)
        REG_SFX_ENABLE: sfx_enable <= pwdata[0];
        REG_STEP_RATE:  step_rate  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_SFX_ENABLE: prdata = {31'd0, sfx_enable};
      REG_STEP_RATE:  prdata = {16'd0, step_rate};
      default:        prdata = 32'd0;
    endcase
  end

endmodule

// File: rtl/smix_sample_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smix_sample_mem
// Sample word store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module smix_sample_mem #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  logic signed [15:0]  wr_data,
  input  logic [AW-1:0]       rd_addr,
  output logic signed [15:0]  rd_data
);

  logic signed [15:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// File: rtl/smix_voice_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smix_voice_mem
// Voice table: base, length, position, volume and loop count per voice.
// ----------------------------------------------------------------------------
module smix_voice_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic                    clk,
  input  logic                    wr_en,
  input  logic [AW-1:0]           wr_addr,
  input  smix_pkg::voice_entry_t  wr_data,
  input  logic [AW-1:0]           rd_addr,
  output smix_pkg::voice_entry_t  rd_data
);
  import smix_pkg::*;

  voice_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// File: rtl/sample_channel_mixer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sample_channel_mixer
// Sound effect mixer: sample store, voice table and per-frame voice walk.
// ----------------------------------------------------------------------------
// Usage:
//   item/item_valid/item_stall carries command beats: load a sample word,
//   start, stop or re-volume a voice, or a frame tick with the music pair.
//   result/result_valid/result_stall carries one mixed left/right beat for
//   every tick and nothing for other commands.
//   Load, start, stop and undefined kinds are done when the beat is taken.
//   Set volume then reads the voice entry and writes it back with the new
//   volume. A tick result appears once the voice table read port has given
//   up one voice per cycle, then up to three pipeline stages (sample read,
//   multiply, accumulate) drain and the output is averaged and saturated.
//   The drain is shorter when the last two voices are idle. The next beat
//   can be taken in the same cycle as the result appears.
//   The result register holds a finished beat while the receiver stalls,
//   and the block keeps taking commands; a following tick waits at its end
//   only if the previous result still sits in the register.
//   Reset clears all voices to idle, sets sfx_enable to 1 and step_rate to
//   128. The sample store and voice table are not cleared: a voice must be
//   started before it plays and only written sample words are read.
//   SAMPLE_WORDS must be a power of two; addresses wrap modulo its size.
// ----------------------------------------------------------------------------
module sample_channel_mixer #(
  parameter int CHANNELS     = 16,
  parameter int SAMPLE_WORDS = 65536
) (
  input  logic               clk,
  input  logic               rst,
  // command beats
  input  smix_pkg::item_t    item,
  input  logic               item_valid,
  output logic               item_stall,
  // mixed output beats
  output smix_pkg::result_t  result,
  output logic               result_valid,
  input  logic               result_stall,
  // register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import smix_pkg::*;

  localparam int CW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int AW     = $clog2(SAMPLE_WORDS);
  localparam int PROD_W = 26;
  localparam int SUM_W  = PROD_W + CW;
  localparam int MIX_W  = SUM_W - 8;
  localparam logic [CW-1:0] LAST_VOICE = CW'(CHANNELS - 1);

  // Sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_VOL_RD = 3'd1;
  localparam logic [2:0] ST_VOL_WR = 3'd2;
  localparam logic [2:0] ST_WALK   = 3'd3;
  localparam logic [2:0] ST_DRAIN  = 3'd4;
  localparam logic [2:0] ST_FINISH = 3'd5;

  // Average music with the effect mix (floor) and clip to 16 bits
  function automatic logic signed [15:0] mix_avg(
    input logic signed [15:0]      music,
    input logic signed [MIX_W-1:0] mix
  );
    logic signed [MIX_W:0] total;
    logic signed [MIX_W:0] half;
    total = (MIX_W + 1)'(music) + (MIX_W + 1)'(mix);
    half  = total >>> 1;
    if (half > (MIX_W + 1)'(OUT_MAX)) begin
      return OUT_MAX;
    end else if (half < (MIX_W + 1)'(OUT_MIN)) begin
      return OUT_MIN;
    end
    return 16'(half);
  endfunction

  // Control state
  logic [2:0]          state;
  logic [CHANNELS-1:0] active;
  logic [CW-1:0]       issue_idx;
  logic                s1_v;
  logic                s2_v;
  logic                s3_v;

  // Payload registers
  logic [CW-1:0]             s1_idx;
  logic [8:0]                s2_vol;
  logic signed [PROD_W-1:0]  s3_prod;
  logic signed [SUM_W-1:0]   sum;
  logic signed [15:0]        music_left;
  logic signed [15:0]        music_right;
  logic [CW-1:0]             cmd_idx;
  logic [8:0]                cmd_vol;

  // Configuration
  logic        sfx_enable;
  logic [15:0] step_rate;

  // Command decode
  logic          item_accept;
  logic [6:0]    ch_ext;
  logic [CW-1:0] ch_idx;
  logic          ch_in_range;
  logic [8:0]    vol_clamped;
  logic          start_go;
  logic [20:0]   load_ext;

  // Memory ports
  logic          voice_wr_en;
  logic [CW-1:0] voice_wr_addr;
  voice_entry_t  voice_wr_data;
  logic [CW-1:0] voice_rd_addr;
  voice_entry_t  voice_rd_data;
  logic              sample_wr_en;
  logic [AW-1:0]     sample_wr_addr;
  logic [AW-1:0]     sample_rd_addr;
  logic signed [15:0] sample_rd_data;

  // Voice update at the table read stage
  logic               voice_act;
  logic               voice_at_end;
  logic               voice_keep;
  logic [24:0]        pos_eff;
  logic [24:0]        pos_new;
  logic signed [15:0] loops_new;
  logic [17:0]        play_sum;
  logic [20:0]        play_ext;
  voice_entry_t       voice_wb;

  logic signed [PROD_W-1:0] prod;
  logic signed [MIX_W-1:0]  mix;
  logic                     result_load;

  // --------------------------------------------------------------------------
  // Register port
  // --------------------------------------------------------------------------
  smix_cfg u_cfg (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .sfx_enable (sfx_enable),
    .step_rate  (step_rate)
  );

  // --------------------------------------------------------------------------
  // Command decode: only the idle sequencer takes a beat
  // --------------------------------------------------------------------------
  assign item_stall  = (state != ST_IDLE);
  assign item_accept = item_valid && !item_stall;

  assign ch_ext      = 7'(item.channel);
  assign ch_idx      = ch_ext[CW-1:0];
  assign ch_in_range = (ch_ext < 7'(CHANNELS));
  assign vol_clamped = (item.volume > VOL_MAX) ? VOL_MAX[8:0] : item.volume[8:0];

  // A start with zero volume or with effects disabled is dropped
  assign start_go = item_accept && (item.kind == KIND_START) && ch_in_range &&
                    sfx_enable && (item.volume != 10'd0);

  // --------------------------------------------------------------------------
  // Sample store: loads write at the accept edge, the walk reads one word
  // per active voice
  // --------------------------------------------------------------------------
  assign load_ext       = 21'(item.sample_address);
  assign sample_wr_en   = item_accept && (item.kind == KIND_LOAD);
  assign sample_wr_addr = load_ext[AW-1:0];

  smix_sample_mem #(
    .DEPTH (SAMPLE_WORDS),
    .AW    (AW)
  ) u_sample_mem (
    .clk     (clk),
    .wr_en   (sample_wr_en),
    .wr_addr (sample_wr_addr),
    .wr_data (item.sample_word),
    .rd_addr (sample_rd_addr),
    .rd_data (sample_rd_data)
  );

  // --------------------------------------------------------------------------
  // Voice update (stage 1): the entry read last cycle is checked against its
  // length, restarted or retired, and written back with the new position.
  // Each voice is touched once per tick, so the write back never meets the
  // read of the same entry.
  // --------------------------------------------------------------------------
  assign voice_act    = active[s1_idx];
  assign voice_at_end = (voice_rd_data.position[24:8] >= voice_rd_data.length);
  assign voice_keep   = voice_act && (!voice_at_end || (voice_rd_data.loops != 16'sd0));
  assign pos_eff      = voice_at_end ? 25'd0 : voice_rd_data.position;
  assign pos_new      = pos_eff + 25'(step_rate);

  // Positive loop counts count down on a restart; negative ones loop forever
  always_comb begin
    loops_new = voice_rd_data.loops;
    if (voice_at_end && !voice_rd_data.loops[15] && (voice_rd_data.loops != 16'sd0)) begin
      loops_new = voice_rd_data.loops - 16'sd1;
    end
  end

  assign play_sum       = 18'(voice_rd_data.base) + 18'(pos_eff[24:8]);
  assign play_ext       = 21'(play_sum);
  assign sample_rd_addr = play_ext[AW-1:0];

  always_comb begin
    voice_wb          = voice_rd_data;
    voice_wb.position = pos_new;
    voice_wb.loops    = loops_new;
  end

  // Voice table ports: volume write back, walk write back or a start
  always_comb begin
    voice_rd_addr = (state == ST_VOL_RD) ? cmd_idx : issue_idx;
    if (state == ST_VOL_WR) begin
      voice_wr_en          = 1'b1;
      voice_wr_addr        = cmd_idx;
      voice_wr_data        = voice_rd_data;
      voice_wr_data.volume = cmd_vol;
    end else if (s1_v) begin
      voice_wr_en   = voice_keep;
      voice_wr_addr = s1_idx;
      voice_wr_data = voice_wb;
    end else begin
      voice_wr_en            = start_go;
      voice_wr_addr          = ch_idx;
      voice_wr_data.base     = item.sample_address;
      voice_wr_data.length   = item.sample_length;
      voice_wr_data.position = 25'd0;
      voice_wr_data.volume   = vol_clamped;
      voice_wr_data.loops    = item.loop_count;
    end
  end

  smix_voice_mem #(
    .DEPTH (CHANNELS),
    .AW    (CW)
  ) u_voice_mem (
    .clk     (clk),
    .wr_en   (voice_wr_en),
    .wr_addr (voice_wr_addr),
    .wr_data (voice_wr_data),
    .rd_addr (voice_rd_addr),
    .rd_data (voice_rd_data)
  );

  // --------------------------------------------------------------------------
  // Stage 2 multiplies the sample by the volume, stage 3 accumulates
  // --------------------------------------------------------------------------
  assign prod = PROD_W'(sample_rd_data) * PROD_W'($signed({1'b0, s2_vol}));

  // Effect sum scaled down by 256 with floor rounding
  assign mix = MIX_W'(sum >>> 8);

  assign result_load = (state == ST_FINISH) && (!result_valid || !result_stall);

  // --------------------------------------------------------------------------
  // Sequencer and control flags
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      active       <= '0;
      issue_idx    <= '0;
      s1_v         <= 1'b0;
      s2_v         <= 1'b0;
      s3_v         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      s1_v <= (state == ST_WALK);
      s2_v <= s1_v && voice_keep;
      s3_v <= s2_v;

      // Raise the beat from the finish state, drop it once taken
      if (result_load) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end

      // Retire a voice that ran out of loops
      if (s1_v && voice_act && !voice_keep) begin
        active[s1_idx] <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (item_accept) begin
            case (item.kind)
              KIND_TICK: begin
                issue_idx <= '0;
                state     <= ST_WALK;
              end
              KIND_START: begin
                if (start_go) begin
                  active[ch_idx] <= 1'b1;
                end
              end
              KIND_STOP: begin
                if (ch_in_range) begin
                  active[ch_idx] <= 1'b0;
                end
              end
              KIND_VOLUME: begin
                if (ch_in_range) begin
                  state <= ST_VOL_RD;
                end
              end
              default: ;
            endcase
          end
        end
        ST_VOL_RD: begin
          state <= ST_VOL_WR;
        end
        ST_VOL_WR: begin
          state <= ST_IDLE;
        end
        ST_WALK: begin
          issue_idx <= issue_idx + CW'(1);
          if (issue_idx == LAST_VOICE) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!s1_v && !s2_v && !s3_v) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (result_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    s1_idx  <= issue_idx;
    s2_vol  <= voice_rd_data.volume;
    s3_prod <= prod;

    if (item_accept && (item.kind == KIND_TICK)) begin
      sum         <= '0;
      music_left  <= item.music_left;
      music_right <= item.music_right;
    end else if (s3_v) begin
      sum <= sum + SUM_W'(s3_prod);
    end

    if (item_accept && (item.kind == KIND_VOLUME)) begin
      cmd_idx <= ch_idx;
      cmd_vol <= vol_clamped;
    end

    if (result_load) begin
      result.out_left  <= mix_avg(music_left, mix);
      result.out_right <= mix_avg(music_right, mix);
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // A result beat is only raised from the finish state
  assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == ST_FINISH)
    else $error("result raised outside finish state");

  // The sum is complete before it is scaled: pipeline empty at finish
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH) |-> (!s1_v && !s2_v && !s3_v))
    else $error("voice pipeline busy at finish");

  // Walk write back never hits the entry being read in the same cycle
  assert property (@(posedge clk) disable iff (rst)
    (s1_v && (state == ST_WALK)) |-> (s1_idx != issue_idx))
    else $error("voice table read and write collide");

  // A multiply only follows an accepted voice update
  assert property (@(posedge clk) disable iff (rst)
    s2_v |-> $past(s1_v))
    else $error("multiply stage valid without update stage");

  // No command beat is taken while a tick is in flight
  assert property (@(posedge clk) disable iff (rst)
    (s1_v || s2_v || s3_v) |-> item_stall)
    else $error("command taken during voice walk");

endmodule

// File: verif/mixer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mixer_checker
// Watches the command, output and register ports of the sample mixer, keeps
// its own sample store, voice table and register copy, predicts every mixed
// output beat and compares it field by field with what the block delivers.
// ----------------------------------------------------------------------------
module mixer_checker
  import smix_pkg::*;
#(
  parameter int         CHANNELS    = 16,
  parameter logic [2:0] ADDR_ENABLE = 3'd0,
  parameter logic [2:0] ADDR_RATE   = 3'd4
) (
  input  logic        clk,
  input  logic        rst,
  input  item_t       item,
  input  logic        item_valid,
  input  logic        item_stall,
  input  result_t     result,
  input  logic        result_valid,
  input  logic        result_stall,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int          mismatches,
  output int          pending
);

  logic signed [15:0] sample_mem [0:65535];
  bit                 voice_on [CHANNELS];
  voice_entry_t       voice [CHANNELS];
  logic               sfx_on;
  logic [15:0]        rate;
  result_t            mix_q [$];

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  task automatic log_mismatch(input string msg);
    $display("%0t mixer mismatch: %s", $time, msg);
    mismatches++;
  endtask

  function automatic logic signed [15:0] avg_sat(input logic signed [15:0] music,
                                                 input longint mix);
    longint v;
    v = (longint'(music) + mix) >>> 1;
    if (v > longint'(OUT_MAX)) v = longint'(OUT_MAX);
    else if (v < longint'(OUT_MIN)) v = longint'(OUT_MIN);
    return v[15:0];
  endfunction

  // Walk the voices for one frame tick and return the mixed output pair
  function automatic result_t mix_tick(input item_t beat);
    longint      sum;
    longint      mix;
    logic [15:0] addr;
    result_t     r;
    sum = 0;
    for (int c = 0; c < CHANNELS; c++) begin
      if (!voice_on[c]) continue;
      if (voice[c].position[24:8] >= voice[c].length) begin
        if (voice[c].loops != 16'sd0) begin
          voice[c].position = '0;
          if (!voice[c].loops[15]) voice[c].loops = voice[c].loops - 16'sd1;
        end else begin
          voice_on[c] = 1'b0;
          continue;
        end
      end
      addr = voice[c].base + voice[c].position[23:8];
      sum += longint'(sample_mem[addr]) * longint'(voice[c].volume);
      voice[c].position = voice[c].position + 25'(rate);
    end
    mix = sum >>> 8;
    r.out_left  = avg_sat(beat.music_left, mix);
    r.out_right = avg_sat(beat.music_right, mix);
    return r;
  endfunction

  always @(posedge clk) begin
    result_t     want;
    logic [31:0] reg_value;
    if (rst) begin
      sfx_on = 1'b1;
      rate   = STEP_RATE_RESET;
      for (int c = 0; c < CHANNELS; c++) voice_on[c] = 1'b0;
      mix_q.delete();
    end else begin
      if (item_valid && !item_stall) begin
        case (item.kind)
          KIND_LOAD: sample_mem[item.sample_address] = item.sample_word;
          KIND_START: begin
            if (item.channel < CHANNELS && sfx_on && item.volume != '0) begin
              voice_on[item.channel]       = 1'b1;
              voice[item.channel].base     = item.sample_address;
              voice[item.channel].length   = item.sample_length;
              voice[item.channel].position = '0;
              voice[item.channel].volume   = (item.volume > VOL_MAX) ? 9'(VOL_MAX)
                                                                     : item.volume[8:0];
              voice[item.channel].loops    = item.loop_count;
            end
          end
          KIND_STOP: begin
            if (item.channel < CHANNELS) voice_on[item.channel] = 1'b0;
          end
          KIND_VOLUME: begin
            if (item.channel < CHANNELS)
              voice[item.channel].volume = (item.volume > VOL_MAX) ? 9'(VOL_MAX)
                                                                   : item.volume[8:0];
          end
          KIND_TICK: mix_q.push_back(mix_tick(item));
          default: ;
        endcase
      end
      if (result_valid && !result_stall) begin
        if (mix_q.size() == 0) begin
          log_mismatch($sformatf("output beat with none expected: left %0d right %0d",
                                 result.out_left, result.out_right));
        end else begin
          want = mix_q.pop_front();
          if (result.out_left !== want.out_left)
            log_mismatch($sformatf("out_left %0d, predicted %0d",
                                   result.out_left, want.out_left));
          if (result.out_right !== want.out_right)
            log_mismatch($sformatf("out_right %0d, predicted %0d",
                                   result.out_right, want.out_right));
        end
      end
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr == ADDR_ENABLE) sfx_on = pwdata[0];
          else if (paddr == ADDR_RATE) rate = pwdata[15:0];
        end else if (paddr == ADDR_ENABLE || paddr == ADDR_RATE) begin
          reg_value = (paddr == ADDR_ENABLE) ? {31'd0, sfx_on} : {16'd0, rate};
          if (prdata !== reg_value)
            log_mismatch($sformatf("register %0d read 0x%0h, held 0x%0h",
                                   paddr, prdata, reg_value));
        end
      end
    end
    pending <= mix_q.size();
  end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the sample mixer with directed and random command beats under
// bursty sending and patterned output stalls, steps through several register
// settings, and lets the checker beside the block judge every output beat.
// ----------------------------------------------------------------------------
module testbench;
  import smix_pkg::*;

  localparam int         CHANNELS       = 16;
  localparam logic [2:0] REG_SFX_ENABLE = 3'd0;
  localparam logic [2:0] REG_STEP_RATE  = 3'd4;
  // A tick walks every voice and drains three stages before its beat shows up
  localparam int         SETTLE         = 2 * (CHANNELS + 5);
  localparam int         IDLE_LIMIT     = 2000;
  localparam int         PHASES         = 6;
  localparam int         PHASE_BEATS    = 285;

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  item_t       item         = '0;
  logic        item_valid   = 1'b0;
  logic        item_stall;
  result_t     result;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic        psel         = 1'b0;
  logic        penable      = 1'b0;
  logic        pwrite       = 1'b0;
  logic [2:0]  paddr        = '0;
  logic [31:0] pwdata       = '0;
  logic [31:0] prdata;
  logic        pready;

  int mismatch_count;
  int beats_pending;

  sample_channel_mixer #(
    .CHANNELS(CHANNELS)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result       (result),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  mixer_checker #(
    .CHANNELS    (CHANNELS),
    .ADDR_ENABLE (REG_SFX_ENABLE),
    .ADDR_RATE   (REG_STEP_RATE)
  ) checker_i (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result       (result),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .mismatches   (mismatch_count),
    .pending      (beats_pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Output stalls: switch between no stalls, light and heavy random stalls and
  // a long periodic stall, holding each mode for a random stretch of cycles.
  int stall_mode;
  int stall_left;

  always @(posedge clk) begin
    if (rst) begin
      stall_mode   <= 0;
      stall_left   <= 0;
      result_stall <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        stall_left <= $urandom_range(20, 200);
      end else begin
        stall_left <= stall_left - 1;
      end
      case (stall_mode)
        0: result_stall <= 1'b0;
        1: result_stall <= ($urandom_range(0, 3) == 0);
        2: result_stall <= ($urandom_range(0, 1) == 0);
        default: result_stall <= ((stall_left % 16) < 11);
      endcase
    end
  end

  // Watchdog: end the run when no beat moves on either channel for too long
  int idle_cycles;

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Shadow of the voice walk, kept only to know which sample words the next
  // tick reads, so that every one of them gets loaded before the tick goes out.
  bit          written [0:65535];
  bit          m_on [CHANNELS];
  logic [15:0] m_base [CHANNELS];
  logic [16:0] m_len [CHANNELS];
  logic [24:0] m_pos [CHANNELS];
  logic signed [15:0] m_loops [CHANNELS];
  logic        m_enable = 1'b1;
  logic [15:0] m_rate   = STEP_RATE_RESET;
  int          burst_left = 0;

  function automatic item_t noise_beat(input logic [2:0] kind);
    logic [127:0] r;
    item_t        b;
    r = {$urandom, $urandom, $urandom, $urandom};
    b = r[$bits(item_t)-1:0];
    b.kind = kind;
    return b;
  endfunction

  function automatic logic signed [15:0] music_value();
    case ($urandom_range(0, 9))
      0: return OUT_MAX;
      1: return OUT_MIN;
      2: return '0;
      default: return 16'($urandom);
    endcase
  endfunction

  // Send one beat: open a random gap between bursts, then hold the beat
  // until it is taken. Valid stays high into the next beat of a burst.
  task automatic send_beat(input item_t b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if ($urandom_range(0, 19) == 0) gap = $urandom_range(20, 60);
      burst_left = $urandom_range(1, 40);
      if (gap != 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    item       <= b;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
  endtask

  task automatic send_load(input logic [15:0] addr, input logic signed [15:0] word);
    item_t b;
    b = noise_beat(KIND_LOAD);
    b.sample_address = addr;
    b.sample_word    = word;
    written[addr]    = 1'b1;
    send_beat(b);
  endtask

  task automatic send_start(input logic [3:0] ch, input logic [15:0] base,
                            input logic [16:0] len, input logic [9:0] vol,
                            input logic signed [15:0] loops);
    item_t b;
    b = noise_beat(KIND_START);
    b.channel        = ch;
    b.sample_address = base;
    b.sample_length  = len;
    b.volume         = vol;
    b.loop_count     = loops;
    if (m_enable && vol != '0) begin
      m_on[ch]    = 1'b1;
      m_base[ch]  = base;
      m_len[ch]   = len;
      m_pos[ch]   = '0;
      m_loops[ch] = loops;
    end
    send_beat(b);
  endtask

  // Stop or set volume on one voice
  task automatic send_voice_cmd(input logic [2:0] kind, input logic [3:0] ch,
                                input logic [9:0] vol);
    item_t b;
    b = noise_beat(kind);
    b.channel = ch;
    b.volume  = vol;
    if (kind == KIND_STOP) m_on[ch] = 1'b0;
    send_beat(b);
  endtask

  task automatic send_tick(input logic signed [15:0] left, input logic signed [15:0] right);
    item_t       b;
    logic [15:0] a;
    logic [15:0] fill_q [$];
    // Advance the shadow walk and note every word this tick will read
    for (int c = 0; c < CHANNELS; c++) begin
      if (!m_on[c]) continue;
      if (m_pos[c][24:8] >= m_len[c]) begin
        if (m_loops[c] != 16'sd0) begin
          m_pos[c] = '0;
          if (!m_loops[c][15]) m_loops[c] = m_loops[c] - 16'sd1;
        end else begin
          m_on[c] = 1'b0;
          continue;
        end
      end
      a = m_base[c] + m_pos[c][23:8];
      if (!written[a]) fill_q.push_back(a);
      m_pos[c] = m_pos[c] + 25'(m_rate);
    end
    // Load missing words with random content, then send the tick itself
    while (fill_q.size() != 0) begin
      a = fill_q.pop_front();
      if (!written[a]) send_load(a, 16'($urandom));
    end
    b = noise_beat(KIND_TICK);
    b.music_left  = left;
    b.music_right = right;
    send_beat(b);
  endtask

  // Setup cycle, then access cycle; leave the bus idle after it
  task automatic reg_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Drop valid, wait for every predicted beat to arrive, then let the
  // block finish any command still in flight.
  task automatic quiesce();
    item_valid <= 1'b0;
    @(posedge clk);
    while (beats_pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    logic              en_val;
    logic [15:0]       rate_val;
    logic [16:0]       len;
    logic [9:0]        vol;
    logic signed [15:0] loops;
    int                r;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Read back reset values of both registers
    reg_access(1'b0, REG_SFX_ENABLE, '0);
    reg_access(1'b0, REG_STEP_RATE, '0);

    // Directed: extreme words, address wrap, clamped and zero volume,
    // zero and longest lengths, stop on an idle voice, undefined kinds.
    send_load(16'h0000, OUT_MAX);
    send_load(16'hFFFF, OUT_MIN);
    send_load(16'h0001, 16'sh1234);
    send_tick(OUT_MAX, OUT_MIN);
    send_start(4'd0, 16'hFFFF, 17'd3, 10'd1023, 16'sd2);
    send_start(4'd15, 16'h0000, 17'd0, 10'd256, -16'sd1);
    send_start(4'd1, 16'h0000, 17'd1, 10'd0, 16'sd0);
    send_start(4'd2, 16'h0000, 17'h10000, 10'd1, 16'sd0);
    send_start(4'd3, 16'h0000, 17'd1, 10'd256, 16'sh7FFF);
    send_tick(OUT_MAX, OUT_MAX);
    send_voice_cmd(KIND_VOLUME, 4'd15, 10'd1023);
    send_voice_cmd(KIND_VOLUME, 4'd3, 10'd0);
    send_tick(OUT_MIN, OUT_MIN);
    send_voice_cmd(KIND_STOP, 4'd1, 10'd0);
    send_beat(noise_beat(3'd5));
    send_beat(noise_beat(3'd6));
    send_beat(noise_beat(3'd7));
    send_tick(16'sd0, 16'sd0);
    send_tick(OUT_MAX, OUT_MIN);
    send_tick(-16'sd1, 16'sd1);
    send_voice_cmd(KIND_STOP, 4'd15, 10'd0);
    send_voice_cmd(KIND_STOP, 4'd0, 10'd0);
    send_tick(16'sd0, 16'sd0);

    // Random phases, each under its own register setting
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin en_val = 1'b1; rate_val = 16'd0;     end
        1: begin en_val = 1'b1; rate_val = 16'hFFFF;  end
        2: begin en_val = 1'b0; rate_val = 16'd300;   end
        3: begin en_val = 1'b1; rate_val = 16'd1;     end
        4: begin en_val = 1'b1; rate_val = 16'($urandom); end
        default: begin en_val = 1'b1; rate_val = STEP_RATE_RESET; end
      endcase
      quiesce();
      reg_access(1'b1, REG_SFX_ENABLE, {31'd0, en_val});
      reg_access(1'b1, REG_STEP_RATE, {16'd0, rate_val});
      reg_access(1'b0, REG_SFX_ENABLE, '0);
      reg_access(1'b0, REG_STEP_RATE, '0);
      m_enable = en_val;
      m_rate   = rate_val;

      for (int n = 0; n < PHASE_BEATS; n++) begin
        r = $urandom_range(0, 99);
        if (r < 38) begin
          send_tick(music_value(), music_value());
        end else if (r < 55) begin
          send_load(16'($urandom), 16'($urandom));
        end else if (r < 70) begin
          // Mostly short samples so that restarts and endings show up often
          r = $urandom_range(0, 99);
          if (r < 70) len = 17'($urandom_range(0, 6));
          else if (r < 90) len = 17'($urandom_range(7, 400));
          else if (r < 95) len = 17'h10000;
          else len = 17'($urandom_range(0, 65536));
          r = $urandom_range(0, 99);
          if (r < 10) vol = '0;
          else if (r < 30) vol = 10'($urandom_range(257, 1023));
          else vol = 10'($urandom_range(1, 256));
          r = $urandom_range(0, 99);
          if (r < 30) loops = -16'sd1;
          else if (r < 45) loops = 16'($urandom);
          else if (r < 60) loops = 16'sd0;
          else loops = 16'($urandom_range(1, 3));
          send_start(4'($urandom), 16'($urandom), len, vol, loops);
        end else if (r < 80) begin
          send_voice_cmd(KIND_STOP, 4'($urandom), 10'($urandom));
        end else if (r < 94) begin
          send_voice_cmd(KIND_VOLUME, 4'($urandom), 10'($urandom));
        end else begin
          send_beat(noise_beat(3'($urandom_range(5, 7))));
        end
      end
    end

    quiesce();
    if (mismatch_count == 0 && beats_pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
